// ===== src/gru_lbr_forward_cell_update_unit_assert.svh =====
// Assertion macros used by the checker file of the GRU cell update unit.
`ifndef GRU_LBR_FORWARD_CELL_UPDATE_UNIT_ASSERT_SVH
`define GRU_LBR_FORWARD_CELL_UPDATE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define GLU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== src/glu_pkg.sv =====
// Package with types, constants and arithmetic helpers of the GRU cell update unit.
`timescale 1ns / 1ps
`default_nettype none
package glu_pkg;
	localparam int WordBits = 24;
	localparam int FracBits = 16;
	localparam int AttBits = FracBits + 1;
	localparam int Latency = 6;
	// Width of a rounded product of two words, kept unsaturated.
	localparam int ProdBits = 2 * WordBits - FracBits + 2;

	typedef logic signed [WordBits-1:0] word_t;

	typedef enum logic [2:0] {
		REG_TEST_MODE = 3'd0,
		REG_AUGRU = 3'd1,
		REG_TRAINING = 3'd2,
		REG_SCALE_U = 3'd3,
		REG_SCALE_R = 3'd4,
		REG_SCALE_C = 3'd5
	} reg_idx_t;

	typedef struct packed {
		word_t x_gate_update;
		word_t h_gate_update;
		word_t x_gate_reset;
		word_t h_gate_reset;
		word_t x_gate_cand;
		word_t h_gate_cand;
		word_t bias_update;
		word_t bias_reset;
		word_t bias_cand_x;
		word_t bias_cand_h;
		word_t prev_state;
		logic [AttBits-1:0] attention;
	} in_item_t;

	typedef struct packed {
		word_t new_state;
		word_t gate_update;
		word_t gate_reset;
		word_t gate_cand;
		word_t recurrent_cand;
		logic ws_valid;
	} out_item_t;

	typedef struct packed {
		logic test_mode;
		logic augru;
		logic training;
		word_t scale_update;
		word_t scale_reset;
		word_t scale_cand;
	} cfg_t;

	localparam logic signed [WordBits+1:0] WMax = (26'sd1 <<< (WordBits-1)) - 26'sd1;
	localparam logic signed [WordBits+1:0] WMin = -(26'sd1 <<< (WordBits-1));

	// Clamp a wide sum to the word range.
	function automatic word_t sat_w(input logic signed [63:0] v);
		if (v > 64'(WMax)) return word_t'(WMax);
		else if (v < 64'(WMin)) return word_t'(WMin);
		else return word_t'(v);
	endfunction

	// Round a raw product half up, dropping the fraction bits.
	function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
		return (p + (64'sd1 <<< (FracBits-1))) >>> FracBits;
	endfunction

	// Piecewise linear sigmoid on a word-range value of up to 26 bits.
	function automatic word_t sigm(input logic signed [WordBits+1:0] x);
		logic signed [WordBits+1:0] a;
		logic signed [WordBits+1:0] y;
		logic signed [WordBits+1:0] one;
		one = 26'sd1 <<< FracBits;
		a = x[WordBits+1] ? -x : x;
		if (a >= 26'sd5 * one) y = one;
		else if (a >= ((26'sd19 * one) >>> 3)) y = (a >>> 5) + ((26'sd27 * one) >>> 5);
		else if (a >= one) y = (a >>> 3) + ((26'sd5 * one) >>> 3);
		else y = (a >>> 2) + (one >>> 1);
		if (x[WordBits+1]) y = one - y;
		return word_t'(y);
	endfunction
endpackage
`default_nettype wire

// ===== src/glu_mulrnd.sv =====
// Registered signed multiply with half-up rounding.
`timescale 1ns / 1ps
`default_nettype none
module glu_mulrnd import glu_pkg::*; (
	input wire logic clk,
	input wire logic signed [WordBits+1:0] a,
	input wire logic signed [WordBits+1:0] b,
	output logic signed [ProdBits-1:0] p_rnd
);
	logic signed [2*WordBits+3:0] prod;
	logic signed [63:0] r;
	// One multiplier, then the rounded product is registered, truncated to ProdBits.
	assign prod = a * b;
	assign r = rnd(64'(prod));
	always_ff @(posedge clk) begin
		p_rnd <= ProdBits'(r);
	end
endmodule
`default_nettype wire

// ===== src/gru_lbr_forward_cell_update_unit.sv =====
// Top level of the linear-before-reset GRU cell element-wise update unit.
// Usage: pulse start with one element on item_in; busy is always low, so one
// element may be taken on every clock. Configuration is written through
// cfg_we, cfg_idx and cfg_data while no element is in flight; unknown
// indexes are ignored. Each element gives one result on item_out, marked by
// done for exactly one cycle. Throughput is one element per clock. The six
// stage pipeline is: gate sums, activations of update and reset, reset
// product, candidate activation, state products, final sum. No stage holds
// more than two multipliers, side by side. The receiver cannot stall, so
// results are never held.
// Reset clears the valid bits of the pipeline and sets the configuration to
// its defaults: linear test mode off, AUGRU off, training off, scales one.
`timescale 1ns / 1ps
`default_nettype none
module gru_lbr_forward_cell_update_unit import glu_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire in_item_t item_in,
	output logic done,
	output out_item_t item_out,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [WordBits-1:0] cfg_data
);
	localparam logic signed [WordBits+1:0] One = 26'sd1 <<< FracBits;
	cfg_t cfg_q;
	logic [Latency-1:0] vld_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{1'b0, 1'b0, 1'b0, word_t'(One), word_t'(One), word_t'(One)};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TEST_MODE: cfg_q.test_mode <= cfg_data[0];
				REG_AUGRU: cfg_q.augru <= cfg_data[0];
				REG_TRAINING: cfg_q.training <= cfg_data[0];
				REG_SCALE_U: cfg_q.scale_update <= cfg_data;
				REG_SCALE_R: cfg_q.scale_reset <= cfg_data;
				REG_SCALE_C: cfg_q.scale_cand <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Latency-2:0], start};
	end
	assign busy = 1'b0;
	assign done = vld_q[Latency-1];

	// Stage 1: saturated gate sums.
	word_t p0_s1, p1_s1, wb_s1, xc_s1, bcx_s1, prev_s1;
	logic [AttBits-1:0] att_s1;
	always_ff @(posedge clk) begin
		p0_s1 <= sat_w(64'(item_in.x_gate_update) + 64'(item_in.h_gate_update)
			+ 64'(item_in.bias_update));
		p1_s1 <= sat_w(64'(item_in.x_gate_reset) + 64'(item_in.h_gate_reset)
			+ 64'(item_in.bias_reset));
		wb_s1 <= sat_w(64'(item_in.h_gate_cand) + 64'(item_in.bias_cand_h));
		xc_s1 <= item_in.x_gate_cand;
		bcx_s1 <= item_in.bias_cand_x;
		prev_s1 <= item_in.prev_state;
		att_s1 <= item_in.attention;
	end

	// Stage 2: update and reset activations.
	logic signed [ProdBits-1:0] um_s2, rm_s2;
	glu_mulrnd u_mu (.clk(clk), .a((WordBits+2)'(cfg_q.scale_update)),
		.b((WordBits+2)'(p0_s1)), .p_rnd(um_s2));
	glu_mulrnd u_mr (.clk(clk), .a((WordBits+2)'(cfg_q.scale_reset)),
		.b((WordBits+2)'(p1_s1)), .p_rnd(rm_s2));
	word_t us_s2, rs_s2, wb_s2, xc_s2, bcx_s2, prev_s2;
	logic [AttBits-1:0] att_s2;
	always_ff @(posedge clk) begin
		us_s2 <= sigm((WordBits+2)'(p0_s1));
		rs_s2 <= sigm((WordBits+2)'(p1_s1));
		wb_s2 <= wb_s1; xc_s2 <= xc_s1; bcx_s2 <= bcx_s1;
		prev_s2 <= prev_s1; att_s2 <= att_s1;
	end
	word_t u2, r2;
	assign u2 = cfg_q.test_mode ? sat_w(64'(um_s2)) : us_s2;
	assign r2 = cfg_q.test_mode ? sat_w(64'(rm_s2)) : rs_s2;

	// Stage 3: reset times biased recurrent term, kept unsaturated for the sum.
	logic signed [ProdBits-1:0] rw_s3;
	glu_mulrnd u_rw (.clk(clk), .a((WordBits+2)'(r2)), .b((WordBits+2)'(wb_s2)),
		.p_rnd(rw_s3));
	word_t u_s3, r_s3, wb_s3, xc_s3, bcx_s3, prev_s3;
	logic [AttBits-1:0] att_s3;
	always_ff @(posedge clk) begin
		u_s3 <= u2; r_s3 <= r2; wb_s3 <= wb_s2; xc_s3 <= xc_s2;
		bcx_s3 <= bcx_s2; prev_s3 <= prev_s2; att_s3 <= att_s2;
	end
	word_t p2;
	assign p2 = sat_w(64'(xc_s3) + 64'(rw_s3) + 64'(bcx_s3));

	// Stage 4: candidate activation and attention scaling of u.
	logic signed [ProdBits-1:0] cm_s4, ua_s4;
	glu_mulrnd u_mc (.clk(clk), .a((WordBits+2)'(cfg_q.scale_cand)),
		.b((WordBits+2)'(p2)), .p_rnd(cm_s4));
	glu_mulrnd u_ma (.clk(clk), .a(One - (WordBits+2)'(att_s3)),
		.b((WordBits+2)'(u_s3)), .p_rnd(ua_s4));
	word_t ct_s4, u_s4, r_s4, wb_s4, prev_s4;
	always_ff @(posedge clk) begin
		ct_s4 <= word_t'(sat_w(64'(sigm((WordBits+2)'(p2) <<< 1)) * 2 - 64'(One)));
		u_s4 <= u_s3; r_s4 <= r_s3; wb_s4 <= wb_s3; prev_s4 <= prev_s3;
	end
	word_t c4, ux4, omu4;
	assign c4 = cfg_q.test_mode ? sat_w(64'(cm_s4)) : ct_s4;
	assign ux4 = cfg_q.augru ? sat_w(64'(ua_s4)) : u_s4;
	assign omu4 = sat_w(64'(One) - 64'(ux4));

	// Stage 5: the two state products, both kept unsaturated for the final sum.
	logic signed [ProdBits-1:0] pa_s5, pb_s5;
	glu_mulrnd u_pa (.clk(clk), .a((WordBits+2)'(prev_s4)), .b((WordBits+2)'(ux4)),
		.p_rnd(pa_s5));
	glu_mulrnd u_pb (.clk(clk), .a((WordBits+2)'(omu4)), .b((WordBits+2)'(c4)),
		.p_rnd(pb_s5));
	word_t u_s5, r_s5, c_s5, wb_s5;
	always_ff @(posedge clk) begin
		u_s5 <= u_s4; r_s5 <= r_s4; c_s5 <= c4; wb_s5 <= wb_s4;
	end

	// Stage 6: final sum into the output register.
	always_ff @(posedge clk) begin
		item_out.new_state <= sat_w(64'(pa_s5) + 64'(pb_s5));
		item_out.gate_update <= u_s5;
		item_out.gate_reset <= r_s5;
		item_out.gate_cand <= c_s5;
		item_out.recurrent_cand <= wb_s5;
		item_out.ws_valid <= cfg_q.training;
	end
endmodule
`default_nettype wire

// ===== src/glu_checker.sv =====
// Port checker of the GRU cell update unit, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "gru_lbr_forward_cell_update_unit_assert.svh"
module glu_checker import glu_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire out_item_t item_out
);
	// A result follows each beat after the full pipeline depth.
	`GLU_ASSERT_IMP(a_lat, clk, arst_n, $past(start, Latency) && $past(arst_n, Latency), done)
	`GLU_ASSERT_IMP(a_nolat, clk, arst_n, !$past(start, Latency) && $past(arst_n, Latency), !done)
	// The unit never refuses a beat.
	`GLU_ASSERT_IMP(a_busy, clk, arst_n, 1'b1, !busy)
	// A result beat carries no unknown bits.
	`GLU_ASSERT_IMP(a_known, clk, arst_n, done, !$isunknown(item_out))
endmodule
bind gru_lbr_forward_cell_update_unit glu_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done), .item_out(item_out));
`default_nettype wire
